>>> src/sst_pkg.sv
// Shared types and constants for the slot schedule table with aging.
// This package has no dependencies. The controller, the datapath and the top level import it.
`timescale 1ns / 1ps

package sst_pkg;

  // Most result beats that one operation reports.
  localparam int MAX_RESULTS = 16;
  localparam int RES_NW      = $clog2(MAX_RESULTS + 1);
  localparam int RES_PW      = $clog2(MAX_RESULTS);

  // Age saturation value.
  localparam logic [7:0] AGE_MAX = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [7:0] OWN_ADDR_RST = 8'd0;
  localparam logic [7:0] TIMEOUT_RST  = 8'd10;
  localparam logic [7:0] FILTER_RST   = 8'd3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_OWN_ADDR = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_FILTER   = 2'd2
  } cfg_idx_e;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_PRESENCE = 3'd1,
    OP_ROUND    = 3'd2,
    OP_SWEEP    = 3'd3,
    OP_FIND     = 3'd4,
    OP_READ     = 3'd5
  } op_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_FOUND    = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_READ     = 3'd3,
    KIND_FILTER   = 3'd4,
    KIND_REMOVED  = 3'd5,
    KIND_FULL     = 3'd6
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DRAIN
  } state_e;

  // One buffered result beat, without count and last.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [7:0]  device;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
    logic pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic out_last;
  } status_t;

endpackage

>>> src/sst_ctrl.sv
// Controller state machine of the slot schedule table.
// It depends on sst_pkg and drives the datapath through cmd_t, reading status_t back.
`timescale 1ns / 1ps

module sst_ctrl
  import sst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st_i.scan_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DRAIN;
      end
      ST_DRAIN: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          if (st_i.out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An accepted item always moves the controller into the scan state.
  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_SCAN)
    else $error("accepted item did not start a scan");

  // The final result beat returns the block to accepting items.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && st_i.out_last |=> in_ready_o)
    else $error("block not ready after final result beat");

endmodule

>>> src/sst_dp.sv
// Datapath of the slot schedule table: slot registers, ages, count, config and result buffer.
// It depends on sst_pkg and is sequenced by sst_ctrl through cmd_t.
`timescale 1ns / 1ps

module sst_dp
  import sst_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  address_i,
  input  logic [3:0]  slot_index_i,
  input  cmd_t        cmd_i,
  output status_t     st_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [7:0]  device_o,
  output logic [4:0]  count_o
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Configuration registers; the own address is held in slot 0 of the table.
  logic [7:0] timeout_q, filter_q;

  // Schedule table and walk state.
  logic [7:0]    addr_q [SLOTS];
  logic [7:0]    addr_d [SLOTS];
  logic [7:0]    age_q  [SLOTS];
  logic [7:0]    age_d  [SLOTS];
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          hit_q, hit_d;

  // Latched item fields.
  op_e        op_q;
  logic [7:0] a_q;
  logic [3:0] sidx_q;

  // Result buffer.
  res_t              res_buf [MAX_RESULTS];
  logic [RES_NW-1:0] res_n_q;
  logic [RES_PW-1:0] rd_ptr_q;
  logic              push;
  res_t              push_res;

  logic [7:0]  cur_addr, cur_age;
  logic        scan_op;
  logic        sidx_ok;
  logic [31:0] cnt_ext, idx_ext;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  assign cur_addr = addr_q[idx_q[IW-1:0]];
  assign cur_age  = age_q[idx_q[IW-1:0]];
  assign idx_ext  = 32'(idx_q);
  assign cnt_ext  = 32'(count_q);
  assign sidx_ok  = 32'(sidx_q) < SLOTS;

  assign scan_op = (op_q == OP_ADD) || (op_q == OP_PRESENCE) || (op_q == OP_ROUND) ||
                   (op_q == OP_SWEEP) || (op_q == OP_FIND);

  assign st_o.scan_end = !scan_op || hit_q || (idx_q >= count_q);
  assign st_o.out_last = (RES_NW'(rd_ptr_q) + RES_NW'(1)) == res_n_q;

  // Output beat fields come from the buffer at the read pointer.
  assign kind_o   = res_buf[rd_ptr_q].kind;
  assign slot_o   = res_buf[rd_ptr_q].slot;
  assign device_o = res_buf[rd_ptr_q].device;
  assign count_o  = cnt_ext[4:0];

  // Config registers: the user must send writes only while the block is idle; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      filter_q  <= FILTER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:  timeout_q <= cfg_data_i;
        CFG_FILTER:   filter_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state of the table and the result to buffer.
  always_comb begin
    addr_d   = addr_q;
    age_d    = age_q;
    count_d  = count_q;
    idx_d    = idx_q;
    hit_d    = hit_q;
    push     = 1'b0;
    push_res = '{kind: KIND_DONE, slot: 4'd0, device: 8'd0};

    if (cmd_i.load) begin
      hit_d = 1'b0;
      case (op_e'(op_i))
        OP_FIND: idx_d = '0;
        OP_READ: idx_d = CW'(slot_index_i);
        default: idx_d = CW'(1);
      endcase
    end

    // One slot per step of the walk.
    if (cmd_i.step) begin
      case (op_q)
        OP_ADD, OP_PRESENCE, OP_FIND: begin
          if (cur_addr == a_q) begin
            if (op_q != OP_FIND) begin
              age_d[idx_q[IW-1:0]] = 8'd0;
            end
            hit_d    = 1'b1;
            push     = 1'b1;
            push_res = '{kind: KIND_FOUND, slot: idx_ext[3:0], device: a_q};
          end
          idx_d = idx_q + CW'(1);
        end
        OP_ROUND: begin
          if (cur_age != AGE_MAX) begin
            age_d[idx_q[IW-1:0]] = cur_age + 8'd1;
          end
          idx_d = idx_q + CW'(1);
        end
        OP_SWEEP: begin
          if (cur_age > timeout_q) begin
            push     = 1'b1;
            push_res = '{kind: KIND_REMOVED, slot: idx_ext[3:0], device: cur_addr};
            // Later slots move up by one; the same index is checked again.
            for (int j = 0; j < SLOTS - 1; j++) begin
              if (CW'(j) >= idx_q) begin
                addr_d[j] = addr_q[j+1];
                age_d[j]  = age_q[j+1];
              end
            end
            addr_d[SLOTS-1] = 8'd0;
            age_d[SLOTS-1]  = 8'd0;
            if (count_q > CW'(1)) begin
              count_d = count_q - CW'(1);
            end
          end else begin
            if (cur_age > filter_q) begin
              push     = 1'b1;
              push_res = '{kind: KIND_FILTER, slot: idx_ext[3:0], device: cur_addr};
            end
            idx_d = idx_q + CW'(1);
          end
        end
        default: ;
      endcase
    end

    // Closing result of the operation.
    if (cmd_i.finish) begin
      case (op_q)
        OP_ADD: begin
          if (!hit_q) begin
            push = 1'b1;
            if (32'(count_q) < SLOTS) begin
              // The walk ended with the index at the first free slot.
              addr_d[idx_q[IW-1:0]] = a_q;
              age_d[idx_q[IW-1:0]]  = 8'd0;
              count_d  = count_q + CW'(1);
              push_res = '{kind: KIND_DONE, slot: idx_ext[3:0], device: a_q};
            end else begin
              push_res = '{kind: KIND_FULL, slot: 4'd0, device: a_q};
            end
          end
        end
        OP_PRESENCE, OP_FIND: begin
          if (!hit_q) begin
            push     = 1'b1;
            push_res = '{kind: KIND_NOTFOUND, slot: 4'd0, device: a_q};
          end
        end
        OP_SWEEP: begin
          if (res_n_q == '0) begin
            push = 1'b1;
          end
        end
        OP_READ: begin
          push = 1'b1;
          if (sidx_ok) begin
            push_res = '{kind: KIND_READ, slot: sidx_q, device: cur_addr};
          end else begin
            push_res = '{kind: KIND_NOTFOUND, slot: sidx_q, device: 8'd0};
          end
        end
        default: begin
          push = 1'b1;
        end
      endcase
    end

    if (cfg_wr && (cfg_idx_e'(cfg_index_i) == CFG_OWN_ADDR)) begin
      addr_d[0] = cfg_data_i;
    end
  end

  // Table, count and walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SLOTS; j++) begin
        addr_q[j] <= 8'd0;
        age_q[j]  <= 8'd0;
      end
      addr_q[0] <= OWN_ADDR_RST;
      count_q   <= CW'(1);
      idx_q     <= '0;
      hit_q     <= 1'b0;
      res_n_q   <= '0;
      rd_ptr_q  <= '0;
    end else begin
      addr_q  <= addr_d;
      age_q   <= age_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      if (cmd_i.load) begin
        res_n_q  <= '0;
        rd_ptr_q <= '0;
      end else begin
        if (push && (res_n_q < RES_NW'(MAX_RESULTS))) begin
          res_n_q <= res_n_q + RES_NW'(1);
        end
        if (cmd_i.pop) begin
          rd_ptr_q <= rd_ptr_q + RES_PW'(1);
        end
      end
    end
  end

  // Item fields and buffered result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      a_q    <= address_i;
      sidx_q <= slot_index_i;
    end
    if (push && (res_n_q < RES_NW'(MAX_RESULTS))) begin
      res_buf[res_n_q[RES_PW-1:0]] <= push_res;
    end
  end

  // The own slot is never removed and the count stays within the table.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(1)) && (32'(count_q) <= SLOTS))
    else $error("device count out of range");

  // A finished operation always leaves at least one beat to deliver.
  a_finish_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (res_n_q != '0))
    else $error("operation finished without a result beat");

endmodule

>>> src/slot_schedule_table_with_aging.sv
// Sequence: load from idle, a walk of one slot per step (up to count), the scan end, a
// finish state, then the result beats as accepted; a sweep walks at most SLOTS-1 checks.
// Items are taken one at a time: a new one only after the previous item's last beat.
// Reset: asynchronous, active low; slot 0 holds the own address, all ages zero, count one.
// Top level of the slot schedule table; it depends on sst_pkg, sst_ctrl and sst_dp.
`timescale 1ns / 1ps

module slot_schedule_table_with_aging
  import sst_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] address_i,
  input  logic [3:0] slot_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [3:0] slot_o,
  output logic [7:0] device_o,
  output logic [4:0] count_o,
  output logic       last_o
);

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Table and result storage.
  sst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .address_i    (address_i),
    .slot_index_i (slot_index_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .device_o     (device_o),
    .count_o      (count_o)
  );

  assign last_o = st.out_last;

endmodule
